// ===== rtl/pet_pkg.sv =====
// Package for the pulse echo flight timer: shared types, register codes and
// fixed constants. No dependencies; every other rtl file imports it.
package pet_pkg;

  // Fixed field widths
  localparam int DELTA_W   = 32;
  localparam int TRIG_W    = 12;
  localparam int TIMEOUT_W = 24;
  localparam int SKEW_W    = 8;
  localparam int DIST_W    = 4;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_HIGH = 2'd0,
    REG_TRIG_LOW  = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_SKEW      = 2'd3
  } cfg_reg_t;

  // Input item commands
  localparam logic CMD_PERIOD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register reset values
  localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST = 12'd4095;
  localparam logic [TRIG_W-1:0]    TRIG_LOW_RST  = 12'd0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 24'd2000000;
  localparam logic [SKEW_W-1:0]    SKEW_RST      = 8'hF6;

  // Distance conversion: feet = floor((delta + 1500) / 1000), clamped
  localparam int US_PER_FT = 1000;
  localparam int ROUND_OFS = 1500;
  localparam int DIST_MAX  = 15;

  // Configuration set handed to the event stage
  typedef struct packed {
    logic [TRIG_W-1:0]    trig_high;
    logic [TRIG_W-1:0]    trig_low;
    logic [TIMEOUT_W-1:0] timeout;
    logic [SKEW_W-1:0]    skew;
  } pet_cfg_t;

  // Result of one window, passed from the event stage to the range stage
  typedef struct packed {
    logic               missed;
    logic               calibrated;
    logic [DELTA_W-1:0] delta;
  } echo_res_t;

endpackage

// ===== rtl/pet_event.sv =====
// Event stage of the pulse echo flight timer: input register, window state,
// reference and skew tracking, and the registered flight delta.
// Depends on pet_pkg.
module pet_event #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pet_pkg::pet_cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [TIME_BITS-1:0]   in_time_us,
  output logic                   res_valid,
  output pet_pkg::echo_res_t     res,
  input  logic                   res_take
);
  import pet_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > TRIG_W) ? SAMPLE_BITS : TRIG_W;

  // Input register
  logic                   s0_valid_r, s0_valid_nxt;
  logic                   s0_cmd_r;
  logic [SAMPLE_BITS-1:0] s0_sample_r;
  logic [TIME_BITS-1:0]   s0_time_r;

  // Window state
  logic                 armed_r, armed_nxt;
  logic [TIME_BITS-1:0] win_start_r, win_start_nxt;
  logic [DELTA_W-1:0]   ref_delay_r, ref_delay_nxt;
  logic                 have_ref_r, have_ref_nxt;
  logic [DELTA_W-1:0]   skew_total_r, skew_total_nxt;

  // Result register
  logic      s1_valid_r, s1_valid_nxt;
  echo_res_t s1_res_r, s1_res_nxt;

  logic                 s1_ready;
  logic                 s0_move;
  logic                 accept;
  logic [CMP_W-1:0]     smp_ext;
  logic                 hit;
  logic [TIME_BITS-1:0] elapsed;
  logic                 timed_out;
  logic [DELTA_W-1:0]   delay;
  logic [DELTA_W-1:0]   ref_sel;
  logic [DELTA_W-1:0]   skew_ext;

  // Handshake: the input register drains whenever the result slot frees
  assign s1_ready = !s1_valid_r || res_take;
  assign s0_move  = s0_valid_r && s1_ready;
  assign in_stall = s0_valid_r && !s1_ready;
  assign accept   = in_valid && !in_stall;

  assign res_valid = s1_valid_r;
  assign res       = s1_res_r;

  // Trigger, timeout and delay arithmetic
  assign smp_ext   = CMP_W'(s0_sample_r);
  assign hit       = (smp_ext >= CMP_W'(cfg.trig_high)) || (smp_ext <= CMP_W'(cfg.trig_low));
  assign elapsed   = s0_time_r - win_start_r;
  assign timed_out = elapsed >= TIME_BITS'(cfg.timeout);
  assign delay     = DELTA_W'(elapsed);
  assign ref_sel   = have_ref_r ? ref_delay_r : delay;
  assign skew_ext  = DELTA_W'($signed(cfg.skew));

  // Next state of the window and the result slot
  always_comb begin
    s0_valid_nxt   = s0_valid_r;
    armed_nxt      = armed_r;
    win_start_nxt  = win_start_r;
    ref_delay_nxt  = ref_delay_r;
    have_ref_nxt   = have_ref_r;
    skew_total_nxt = skew_total_r;
    s1_valid_nxt   = s1_valid_r;
    s1_res_nxt     = s1_res_r;

    if (accept) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_move) begin
      s0_valid_nxt = 1'b0;
    end

    if (res_take) begin
      s1_valid_nxt = 1'b0;
    end

    if (s0_move) begin
      s1_valid_nxt = 1'b0;
      s1_res_nxt   = '{missed: 1'b1, calibrated: 1'b0, delta: '0};
      if (s0_cmd_r == CMD_PERIOD) begin
        // Close any open window as missed, then rearm
        if (armed_r) begin
          s1_valid_nxt   = 1'b1;
          skew_total_nxt = skew_total_r + skew_ext;
        end
        armed_nxt     = 1'b1;
        win_start_nxt = s0_time_r;
      end else if (armed_r) begin
        if (hit) begin
          // Pulse arrival: first hit ever sets the reference
          s1_valid_nxt          = 1'b1;
          s1_res_nxt.missed     = 1'b0;
          s1_res_nxt.calibrated = !have_ref_r;
          s1_res_nxt.delta      = delay - ref_sel - skew_total_r;
          ref_delay_nxt         = ref_sel;
          have_ref_nxt          = 1'b1;
          skew_total_nxt        = skew_total_r + skew_ext;
          armed_nxt             = 1'b0;
        end else if (timed_out) begin
          s1_valid_nxt   = 1'b1;
          skew_total_nxt = skew_total_r + skew_ext;
          armed_nxt      = 1'b0;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      armed_r      <= 1'b0;
      win_start_r  <= '0;
      ref_delay_r  <= '0;
      have_ref_r   <= 1'b0;
      skew_total_r <= '0;
    end else begin
      s0_valid_r   <= s0_valid_nxt;
      s1_valid_r   <= s1_valid_nxt;
      armed_r      <= armed_nxt;
      win_start_r  <= win_start_nxt;
      ref_delay_r  <= ref_delay_nxt;
      have_ref_r   <= have_ref_nxt;
      skew_total_r <= skew_total_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_cmd_r    <= in_command;
      s0_sample_r <= in_sample;
      s0_time_r   <= in_time_us;
    end
    s1_res_r <= s1_res_nxt;
  end

endmodule

// ===== rtl/pet_range.sv =====
// Range stage of the pulse echo flight timer: converts the flight delta to
// feet and holds the output item register. Depends on pet_pkg.
module pet_range (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  input  pet_pkg::echo_res_t          res,
  output logic                        res_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_missed,
  output logic                        out_calibrated,
  output logic signed [pet_pkg::DELTA_W-1:0] out_flight_delta_us,
  output logic [pet_pkg::DIST_W-1:0]  out_distance_ft
);
  import pet_pkg::*;

  localparam int SUM_W = DELTA_W + 1;

  logic                     out_valid_r, out_valid_nxt;
  logic                     missed_r;
  logic                     cal_r;
  logic [DELTA_W-1:0]       delta_r;
  logic [DIST_W-1:0]        dist_r;

  logic                     take_ok;
  logic signed [SUM_W-1:0]  rounded;
  logic [DIST_W-1:0]        feet;

  // Output register frees when empty or when the item leaves
  assign take_ok  = !out_valid_r || !out_stall;
  assign res_take = res_valid && take_ok;

  // Feet: pick the highest 1000 us step the rounded delta reaches
  assign rounded = SUM_W'($signed(res.delta)) + SUM_W'(ROUND_OFS);

  always_comb begin
    feet = '0;
    if (!res.missed && !rounded[SUM_W-1]) begin
      for (int k = 1; k <= DIST_MAX; k++) begin
        if (rounded >= SUM_W'(k * US_PER_FT)) begin
          feet = DIST_W'(k);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take_ok) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the payload with each item taken
  always_ff @(posedge clk) begin
    if (res_take) begin
      missed_r <= res.missed;
      cal_r    <= res.calibrated;
      delta_r  <= res.delta;
      dist_r   <= feet;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_missed          = missed_r;
  assign out_calibrated      = cal_r;
  assign out_flight_delta_us = $signed(delta_r);
  assign out_distance_ft     = dist_r;

endmodule

// ===== rtl/pulse_echo_flight_timer.sv =====
// Top level of the pulse echo flight timer: configuration registers and the
// event and range stages. Depends on pet_pkg, pet_event and pet_range.
//
// Ultrasonic time-of-flight ranger. A period start item (command 0) arms a
// window stamped with its microsecond time; a sample item (command 1) at or
// above trigger_high, or at or below trigger_low, ends the armed window as a
// hit and reports delay minus the reference delay (set by the first hit ever)
// minus the running skew total, plus the distance in feet, rounded and
// clamped to 0..15. A window that reaches timeout_us, or that is still open
// at the next period start, is reported missed with all other fields zero.
// The block accepts one item every clock cycle while the input is not stalled;
// a result passes through the input register, event register and output
// register, and the input stalls only when the output side holds back.
// Write configuration only while the block is idle.
module pulse_echo_flight_timer #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pet_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pet_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  input  logic [TIME_BITS-1:0]                in_time_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_missed,
  output logic                                out_calibrated,
  output logic signed [pet_pkg::DELTA_W-1:0]  out_flight_delta_us,
  output logic [pet_pkg::DIST_W-1:0]          out_distance_ft
);
  import pet_pkg::*;

  pet_cfg_t  cfg_r, cfg_nxt;
  logic      res_valid;
  echo_res_t res;
  logic      res_take;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRIG_HIGH: cfg_nxt.trig_high = cfg_wdata[TRIG_W-1:0];
        REG_TRIG_LOW:  cfg_nxt.trig_low  = cfg_wdata[TRIG_W-1:0];
        REG_TIMEOUT:   cfg_nxt.timeout   = cfg_wdata[TIMEOUT_W-1:0];
        REG_SKEW:      cfg_nxt.skew      = cfg_wdata[SKEW_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{trig_high: TRIG_HIGH_RST, trig_low: TRIG_LOW_RST,
                 timeout: TIMEOUT_RST, skew: SKEW_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pet_event #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_event (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_sample  (in_sample),
    .in_time_us (in_time_us),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  pet_range u_range (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_valid           (res_valid),
    .res                 (res),
    .res_take            (res_take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_missed          (out_missed),
    .out_calibrated      (out_calibrated),
    .out_flight_delta_us (out_flight_delta_us),
    .out_distance_ft     (out_distance_ft)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pulse_echo_flight_timer: directed and random ranging items
// checked against an in-bench predictor. Depends on pet_pkg and the rtl top level only.
module tb;
  import pet_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_PAD   = 8;
  localparam int HOLD_CYCLES = 250;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [11:0]          in_sample;
  logic [31:0]          in_time_us;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_missed;
  logic                 out_calibrated;
  logic signed [31:0]   out_flight_delta_us;
  logic [3:0]           out_distance_ft;

  typedef struct {
    logic        missed;
    logic        calibrated;
    logic [31:0] delta;
    logic [3:0]  feet;
  } echo_t;

  echo_t pending_echoes[$];
  int    mismatches = 0;
  int    sent_count = 0;
  int    cycle_count = 0;
  int    hold_req = 0;
  bit    quiet = 1'b0;

  // Predictor copy of the configuration registers
  logic [11:0] trig_high_cfg;
  logic [11:0] trig_low_cfg;
  logic [23:0] timeout_cfg;
  logic [7:0]  skew_cfg;

  // Predictor copy of the window state
  logic        armed_st;
  logic [31:0] win_start_st;
  logic [31:0] ref_delay_st;
  logic        have_ref_st;
  logic [31:0] skew_sum_st;

  pulse_echo_flight_timer dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Feet from a signed delta: floor((delta + 1500) / 1000), clamped to 0..15
  function automatic logic [3:0] feet_of(input logic [31:0] delta);
    longint v;
    v = longint'(signed'(delta)) + ROUND_OFS;
    if (v < 0) return 4'd0;
    v = v / US_PER_FT;
    if (v > DIST_MAX) return 4'(DIST_MAX);
    return v[3:0];
  endfunction

  // Advance the predicted state by one accepted item and queue any result
  function automatic void predict_echo(input logic cmd, input logic [11:0] smp,
                                       input logic [31:0] t_us);
    logic [31:0] elapsed;
    logic [31:0] skew_ext;
    echo_t       e;
    skew_ext = {{24{skew_cfg[7]}}, skew_cfg};
    e = '{missed: 1'b1, calibrated: 1'b0, delta: 32'd0, feet: 4'd0};
    if (cmd == CMD_PERIOD) begin
      if (armed_st) begin
        pending_echoes.push_back(e);
        skew_sum_st = skew_sum_st + skew_ext;
      end
      armed_st = 1'b1;
      win_start_st = t_us;
    end else if (armed_st) begin
      elapsed = t_us - win_start_st;
      if (smp >= trig_high_cfg || smp <= trig_low_cfg) begin
        e.missed = 1'b0;
        if (!have_ref_st) begin
          ref_delay_st = elapsed;
          have_ref_st = 1'b1;
          e.calibrated = 1'b1;
        end
        e.delta = elapsed - ref_delay_st - skew_sum_st;
        e.feet = feet_of(e.delta);
        pending_echoes.push_back(e);
        skew_sum_st = skew_sum_st + skew_ext;
        armed_st = 1'b0;
      end else if (elapsed >= {8'd0, timeout_cfg}) begin
        pending_echoes.push_back(e);
        skew_sum_st = skew_sum_st + skew_ext;
        armed_st = 1'b0;
      end
    end
  endfunction

  // Result side: random stalls, long holds on request, compare each item
  initial begin : result_sink
    int    n;
    echo_t got;
    echo_t want;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (out_valid !== 1'b1);
      got.missed = out_missed;
      got.calibrated = out_calibrated;
      got.delta = out_flight_delta_us;
      got.feet = out_distance_ft;
      @(posedge clk);
      if (pending_echoes.size() == 0) begin
        $display("%0t: result with nothing expected: missed %0b delta %0d feet %0d",
                 $time, got.missed, signed'(got.delta), got.feet);
        mismatches++;
      end else begin
        want = pending_echoes.pop_front();
        if (got.missed !== want.missed) begin
          $display("%0t: missed expected %0b actual %0b", $time, want.missed, got.missed);
          mismatches++;
        end
        if (got.calibrated !== want.calibrated) begin
          $display("%0t: calibrated expected %0b actual %0b", $time, want.calibrated,
                   got.calibrated);
          mismatches++;
        end
        if (got.delta !== want.delta) begin
          $display("%0t: flight_delta_us expected %0d actual %0d", $time,
                   signed'(want.delta), signed'(got.delta));
          mismatches++;
        end
        if (got.feet !== want.feet) begin
          $display("%0t: distance_ft expected %0d actual %0d", $time, want.feet, got.feet);
          mismatches++;
        end
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic cmd, input logic [11:0] smp, input logic [31:0] t_us);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample <= smp;
    in_time_us <= t_us;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    predict_echo(cmd, smp, t_us);
    sent_count++;
  endtask

  // Drop valid and wait until every expected item is back, plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles; unused upper bits get junk
  task automatic program_regs(input logic [11:0] th, input logic [11:0] tl,
                              input logic [23:0] tmo, input logic [7:0] sk);
    logic [23:0] junk;
    junk = 24'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= REG_TRIG_HIGH;
    cfg_wdata <= {junk[11:0], th};
    @(posedge clk);
    cfg_index <= REG_TRIG_LOW;
    cfg_wdata <= {junk[23:12], tl};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= REG_SKEW;
    cfg_wdata <= {junk[15:0], sk};
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_high_cfg = th;
    trig_low_cfg = tl;
    timeout_cfg = tmo;
    skew_cfg = sk;
  endtask

  // Sample that lands a chosen delta in the current window
  task automatic hit_with_delta(input logic [31:0] delta, input logic [11:0] level);
    send_item(CMD_SAMPLE, level, win_start_st + ref_delay_st + skew_sum_st + delta);
  endtask

  function automatic logic [11:0] hit_level();
    if ($urandom_range(0, 1) == 1) return 12'($urandom_range(trig_high_cfg, 4095));
    return 12'($urandom_range(0, trig_low_cfg));
  endfunction

  function automatic logic [11:0] calm_level();
    if (trig_high_cfg > trig_low_cfg + 1)
      return 12'($urandom_range(trig_low_cfg + 1, trig_high_cfg - 1));
    return 12'($urandom_range(0, 4095));
  endfunction

  // Mostly well-formed windows with random content, some noise and broken windows
  task automatic run_windows(input int n_items);
    int          stop_at;
    int          kind;
    int          k;
    int          i;
    int          step_max;
    logic [31:0] t0;
    logic [31:0] t;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 24) == 0) quiet = !quiet;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_item(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)), $urandom);
      end else begin
        t0 = $urandom;
        t = t0;
        send_item(CMD_PERIOD, 12'($urandom_range(0, 4095)), t0);
        // kind 1 leaves the window open for the next period start
        if (kind != 1) begin
          step_max = (timeout_cfg > 60000) ? 20000 : int'(timeout_cfg) / 3 + 1;
          k = $urandom_range(0, 6);
          for (i = 0; i < k; i++) begin
            t = t + $urandom_range(0, step_max);
            send_item(CMD_SAMPLE, calm_level(), t);
          end
          case ($urandom_range(0, 3))
            0: ;
            1: send_item(CMD_SAMPLE, hit_level(), t + $urandom_range(0, step_max));
            2: hit_with_delta($urandom_range(0, 20000) - 3000, hit_level());
            default: send_item(CMD_SAMPLE, calm_level(),
                               t0 + timeout_cfg - 1 + $urandom_range(0, 2));
          endcase
        end
      end
    end
  endtask

  // Samples before any period start are dropped
  task automatic test_idle_samples();
    send_item(CMD_SAMPLE, 12'd4095, 32'd0);
    send_item(CMD_SAMPLE, 12'd0, 32'd100);
  endtask

  // First hit sets the reference; a low-side hit follows
  task automatic test_calibration();
    send_item(CMD_PERIOD, 12'd0, 32'd1000);
    send_item(CMD_SAMPLE, 12'd4095, 32'd6000);
    send_item(CMD_PERIOD, 12'hFFF, 32'd20000);
    send_item(CMD_SAMPLE, 12'd0, 32'd26000);
  endtask

  // Period start over an open window, then timeout right at the boundary
  task automatic test_missed_windows();
    send_item(CMD_PERIOD, 12'd0, 32'd40000);
    send_item(CMD_PERIOD, 12'd0, 32'd50000);
    send_item(CMD_SAMPLE, 12'd2000, 32'd50000 + 32'd1999999);
    send_item(CMD_SAMPLE, 12'd2000, 32'd50000 + 32'd2000000);
  endtask

  // A hit past the timeout still counts as a hit
  task automatic test_trigger_over_timeout();
    send_item(CMD_PERIOD, 12'd0, 32'd3000000);
    send_item(CMD_SAMPLE, 12'd4095, 32'd5500000);
  endtask

  // Window straddling the timestamp wrap
  task automatic test_time_wrap();
    send_item(CMD_PERIOD, 12'd0, 32'hFFFF_F000);
    send_item(CMD_SAMPLE, 12'd0, 32'h0000_0800);
  endtask

  // Distance rounding and clamp edges
  task automatic test_distance_limits();
    send_item(CMD_PERIOD, 12'd0, 32'd10000000);
    hit_with_delta(32'd13499, 12'd4095);
    send_item(CMD_PERIOD, 12'd0, 32'd20000000);
    hit_with_delta(32'd13500, 12'd0);
    send_item(CMD_PERIOD, 12'd0, 32'd30000000);
    hit_with_delta(-32'sd1501, 12'd4095);
    send_item(CMD_PERIOD, 12'd0, 32'd40000000);
    hit_with_delta(-32'sd500, 12'd0);
  endtask

  // Zero timeout ends a window at its first non-hit sample
  task automatic test_zero_timeout();
    settle();
    program_regs(12'd4095, 12'd0, 24'd0, 8'h7F);
    send_item(CMD_PERIOD, 12'd0, 32'd777);
    send_item(CMD_SAMPLE, 12'd2048, 32'd777);
    send_item(CMD_PERIOD, 12'd0, 32'd900);
    send_item(CMD_SAMPLE, 12'd2048, 32'd850);
  endtask

  // Random windows under several register settings, extremes included
  task automatic test_random_settings();
    settle();
    program_regs(12'd3000, 12'd500, 24'd40000, 8'h80);
    run_windows(500);
    settle();
    program_regs(12'd4095, 12'd0, 24'hFFFFFF, 8'h7F);
    run_windows(450);
    settle();
    program_regs(12'd0, 12'd4095, 24'd1, 8'h00);
    run_windows(150);
    settle();
    program_regs(12'd3500, 12'd200, 24'd25000, 8'h05);
    run_windows(500);
  endtask

  // Long receiver hold while items keep coming, then a full pause on the input
  task automatic test_backpressure();
    int          i;
    logic [31:0] t;
    quiet = 1'b1;
    hold_req = HOLD_CYCLES;
    for (i = 0; i < 40; i++) begin
      t = $urandom;
      send_item(CMD_PERIOD, 12'd0, t);
      send_item(CMD_SAMPLE, hit_level(), t + $urandom_range(0, 9000));
    end
    in_valid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    quiet = 1'b0;
    run_windows(200);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_PERIOD;
    in_sample <= '0;
    in_time_us <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TRIG_HIGH;
    cfg_wdata <= '0;
    trig_high_cfg = TRIG_HIGH_RST;
    trig_low_cfg = TRIG_LOW_RST;
    timeout_cfg = TIMEOUT_RST;
    skew_cfg = SKEW_RST;
    armed_st = 1'b0;
    win_start_st = '0;
    ref_delay_st = '0;
    have_ref_st = 1'b0;
    skew_sum_st = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_samples();
    test_calibration();
    test_missed_windows();
    test_trigger_over_timeout();
    test_time_wrap();
    test_distance_limits();
    test_zero_timeout();
    test_random_settings();
    test_backpressure();

    settle();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
